[sv/vram_pixel_writer_overlay_top_defines.svh]
// assertion macros used by the checker file
`ifndef VRAM_PIXEL_WRITER_OVERLAY_TOP_DEFINES_SVH
`define VRAM_PIXEL_WRITER_OVERLAY_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define VPWO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define VPWO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// same-cycle implication that also holds through reset
`define VPWO_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/vpwo_pkg.sv]
// shared types, constants and the colour band decode
package vpwo_pkg;

    localparam int VIDEO_BASE  = 9216;
    localparam int BAND_ORIGIN = 264;
    localparam int QUEUE_DEPTH = 2;
    localparam int COORD_W     = 11;
    localparam int INDEX_W     = 20;
    localparam int COLOR_W     = 32;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COLOR_W-1:0] color_t;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_CLEAR = 1'b1
    } opcode_e;

    typedef enum logic [2:0]
    {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_WHITE_COLOR   = 3'd2,
        REG_GREEN_COLOR   = 3'd3,
        REG_RED_COLOR     = 3'd4,
        REG_BLACK_COLOR   = 3'd5
    } reg_index_e;

    typedef enum logic [1:0]
    {
        BAND_WHITE,
        BAND_GREEN,
        BAND_RED
    } band_e;

    typedef struct packed
    {
        logic        opcode;
        logic [13:0] video_address;
        logic [7:0]  data_byte;
    } cmd_t;

    typedef struct packed
    {
        logic [INDEX_W-1:0] pixel_index;
        color_t             pixel_color;
        logic               last_pixel;
        coord_t             dirty_min_x;
        coord_t             dirty_max_x;
        coord_t             dirty_min_y;
        coord_t             dirty_max_y;
    } pix_t;

    typedef struct packed
    {
        coord_t screen_width;
        coord_t screen_height;
        color_t white_color;
        color_t green_color;
        color_t red_color;
        color_t black_color;
    } cfg_t;

    typedef struct packed
    {
        coord_t left;
        coord_t right;
        coord_t top;
        coord_t bottom;
    } rect_t;

    localparam rect_t RECT_EMPTY = '{left: '1, right: '0, top: '1, bottom: '0};

    // one changed byte handed from the front to the pixel writer
    typedef struct packed
    {
        coord_t     x;
        coord_t     y;
        logic [7:0] data;
        color_t     color;
        rect_t      rect;
    } job_t;

    function automatic band_e band_of(coord_t x, coord_t y);
        band_e b;
        b = BAND_WHITE;
        if (y >= coord_t'(BAND_ORIGIN - 72) && y < coord_t'(BAND_ORIGIN - 16))
        begin
            b = BAND_GREEN;
        end
        // partial bottom strip
        if (y >= coord_t'(BAND_ORIGIN - 16) && x > coord_t'(16) && x < coord_t'(134))
        begin
            b = BAND_GREEN;
        end
        if (y >= coord_t'(BAND_ORIGIN - 224) && y < coord_t'(BAND_ORIGIN - 192))
        begin
            b = BAND_RED;
        end
        return b;
    endfunction

endpackage

[sv/vram_pixel_writer_overlay_top.sv]
// top level: configuration registers, front end, job queue and pixel writer
//
// cmd channel (cmd_valid, cmd_stall, cmd): one item per cpu write to video
// ram, or a clear of the dirty rectangle. an item is taken when cmd_valid is
// high and cmd_stall is low.
// pix channel (pix_valid, pix_stall, pix): eight pixel items for every byte
// that differs from the kept copy, bit 0 first, last_pixel set on the eighth.
// unchanged bytes, addresses outside video ram and clears give no items.
// cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): register writes,
// always ready; write only while no item is in flight.
// a taken item is registered in the front end, written into the job queue and
// loaded into the pixel register. the pixel writer emits one pixel a cycle when
// pix_stall is low; bytes that give no pixels pass at one a cycle, cmd_stall low.
// the front end reads and writes the video copy through one memory port pair
// and a two-entry job queue lets it run ahead of the pixel writer.
// after reset the video copy is cleared one byte a cycle over all VIDEO_BYTES
// entries (7168 by default), cmd_stall held high; cfg writes are taken meanwhile.
// while pix_stall is high the pixel item holds, the queue fills and then
// cmd_stall rises for the next byte that would need it.
module vram_pixel_writer_overlay_top import vpwo_pkg::*;
#(
    parameter int VIDEO_BYTES = 7168
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_t        cmd,
    output logic        pix_valid,
    input  logic        pix_stall,
    output pix_t        pix,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;

    logic job_push;
    job_t job_in;
    logic job_full;
    logic job_pop;
    logic job_valid;
    job_t job_head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[COORD_W-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[COORD_W-1:0];
                REG_WHITE_COLOR:   cfg_next.white_color   = cfg_data;
                REG_GREEN_COLOR:   cfg_next.green_color   = cfg_data;
                REG_RED_COLOR:     cfg_next.red_color     = cfg_data;
                REG_BLACK_COLOR:   cfg_next.black_color   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= coord_t'(224);
            cfg_reg.screen_height <= coord_t'(256);
            cfg_reg.white_color   <= 32'hFFFF_FFFF;
            cfg_reg.green_color   <= 32'hFF00_FF00;
            cfg_reg.red_color     <= 32'hFF00_00FF;
            cfg_reg.black_color   <= 32'hFF00_0000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vpwo_front
    #(
        .VIDEO_BYTES (VIDEO_BYTES)
    )
    u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .job_push  (job_push),
        .job       (job_in),
        .job_full  (job_full)
    );

    vpwo_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job_in),
        .full     (job_full),
        .pop      (job_pop),
        .nonempty (job_valid),
        .head     (job_head)
    );

    vpwo_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_head),
        .job_pop   (job_pop),
        .cfg       (cfg_reg),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix)
    );

endmodule

[sv/vpwo_queue.sv]
// short job queue between the byte front end and the pixel writer
module vpwo_queue import vpwo_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output job_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[sv/vpwo_front.sv]
// front end: video copy compare, dirty rectangle and band classification
module vpwo_front import vpwo_pkg::*;
#(
    parameter int VIDEO_BYTES = 7168
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    input  cfg_t cfg,
    output logic job_push,
    output job_t job,
    input  logic job_full
);

    localparam int ADDR_W = $clog2(VIDEO_BYTES);
    localparam int EXT_W  = 17;
    localparam logic [EXT_W-1:0]  BASE_LO    = EXT_W'(VIDEO_BASE);
    localparam logic [EXT_W-1:0]  BASE_HI    = EXT_W'(VIDEO_BASE + VIDEO_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(VIDEO_BYTES - 1);

    typedef struct packed
    {
        logic              op;
        logic              hit;
        logic [ADDR_W-1:0] offset;
        logic [7:0]        data;
    } stage_t;

    logic [7:0]        mem [VIDEO_BYTES];
    logic [7:0]        rd_data_reg;

    logic              clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              s1_valid_reg, s1_valid_next;
    stage_t            s1_reg, s1_next;
    logic              byp_reg, byp_next;
    logic [7:0]        byp_data_reg, byp_data_next;
    rect_t             rect_reg, rect_next;

    logic              accept;
    logic [EXT_W-1:0]  addr_ext;
    logic              in_hit;
    logic [ADDR_W-1:0] in_offset;
    logic [7:0]        stored;
    logic              changed;
    logic              s1_block;
    logic              s1_done;
    logic              mem_re;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    coord_t            x;
    coord_t            y;
    coord_t            right_cand;
    coord_t            top_cand;
    band_e             band;

    assign addr_ext  = {3'b000, cmd.video_address};
    assign in_hit    = (addr_ext >= BASE_LO) && (addr_ext < BASE_HI);
    assign in_offset = ADDR_W'(addr_ext - BASE_LO);

    // a byte written by the item just ahead is not yet visible in the read data
    assign stored   = byp_reg ? byp_data_reg : rd_data_reg;
    assign changed  = s1_valid_reg && (s1_reg.op == OP_WRITE) && s1_reg.hit
                      && (stored != s1_reg.data);
    assign s1_block = changed && job_full;
    assign s1_done  = s1_valid_reg && !s1_block;
    assign job_push = changed && !job_full;

    assign cmd_stall = clr_busy_reg || s1_block;
    assign accept    = cmd_valid && !cmd_stall;

    assign mem_re    = accept && (cmd.opcode == OP_WRITE) && in_hit;
    assign mem_we    = clr_busy_reg || job_push;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : s1_reg.offset;
    assign mem_wdata = clr_busy_reg ? 8'h00 : s1_reg.data;

    assign x          = COORD_W'(s1_reg.offset >> 5);
    assign y          = cfg.screen_height - coord_t'({s1_reg.offset[4:0], 3'b000});
    assign right_cand = x + coord_t'(1);
    assign top_cand   = y - coord_t'(8);
    assign band       = band_of(x, y);

    always_comb
    begin
        rect_next = rect_reg;
        if (s1_done && (s1_reg.op == OP_CLEAR))
        begin
            rect_next = RECT_EMPTY;
        end
        else if (job_push)
        begin
            if (x < rect_reg.left)
            begin
                rect_next.left = x;
            end
            if (right_cand > rect_reg.right)
            begin
                rect_next.right = right_cand;
            end
            if (top_cand < rect_reg.top)
            begin
                rect_next.top = top_cand;
            end
            if (y > rect_reg.bottom)
            begin
                rect_next.bottom = y;
            end
        end
    end

    always_comb
    begin
        job.x    = x;
        job.y    = y;
        job.data = s1_reg.data;
        job.rect = rect_next;
        case (band)
            BAND_GREEN: job.color = cfg.green_color;
            BAND_RED:   job.color = cfg.red_color;
            default:    job.color = cfg.white_color;
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        byp_next      = byp_reg;
        byp_data_next = byp_data_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_next       = '{op: cmd.opcode, hit: in_hit, offset: in_offset,
                              data: cmd.data_byte};
            byp_next      = job_push && (in_offset == s1_reg.offset);
            byp_data_next = s1_reg.data;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // clearing pass over the video copy after reset
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == LAST_ENTRY)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
            rect_reg     <= RECT_EMPTY;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            s1_valid_reg <= s1_valid_next;
            byp_reg      <= byp_next;
            rect_reg     <= rect_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg       <= s1_next;
        byp_data_reg <= byp_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[in_offset];
        end
    end

endmodule

[sv/vpwo_back.sv]
// pixel writer: eight pixel items per job, lowest row first
module vpwo_back import vpwo_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    input  job_t job,
    output logic job_pop,
    input  cfg_t cfg,
    output logic pix_valid,
    input  logic pix_stall,
    output pix_t pix
);

    localparam logic [2:0] LAST_BIT = 3'd7;

    logic [2:0]           bit_reg, bit_next;
    logic                 pix_valid_reg, pix_valid_next;
    pix_t                 pix_reg, pix_next;

    logic                 load;
    coord_t               row;
    logic [2*COORD_W-1:0] row_offset;
    logic [2*COORD_W-1:0] index_sum;

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    assign load    = job_valid && (!pix_valid_reg || !pix_stall);
    assign job_pop = load && (bit_reg == LAST_BIT);

    assign row        = job.y - coord_t'(bit_reg) - coord_t'(1);
    assign row_offset = (2*COORD_W)'(row) * (2*COORD_W)'(cfg.screen_width);
    assign index_sum  = row_offset + (2*COORD_W)'(job.x);

    always_comb
    begin
        pix_next       = pix_reg;
        pix_valid_next = pix_valid_reg;
        bit_next       = bit_reg;
        if (load)
        begin
            pix_valid_next       = 1'b1;
            bit_next             = bit_reg + 3'd1;
            pix_next.pixel_index = INDEX_W'(index_sum);
            pix_next.pixel_color = job.data[bit_reg] ? job.color : cfg.black_color;
            pix_next.last_pixel  = (bit_reg == LAST_BIT);
            pix_next.dirty_min_x = job.rect.left;
            pix_next.dirty_max_x = job.rect.right;
            pix_next.dirty_min_y = job.rect.top;
            pix_next.dirty_max_y = job.rect.bottom;
        end
        else if (!pix_stall)
        begin
            pix_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            bit_reg       <= '0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            bit_reg       <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

endmodule

[sv/vpwo_checker.sv]
// port-level checks on the top level, bound in below
`include "vram_pixel_writer_overlay_top_defines.svh"

module vpwo_checker import vpwo_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_stall,
    input logic pix_valid,
    input logic pix_stall,
    input pix_t pix
);

    // a stalled pixel item holds
    `VPWO_ASSERT_NEXT(a_pix_hold, pix_valid && pix_stall, pix_valid && $stable(pix), "pixel item changed while stalled")

    // the eight pixels of one byte follow without a gap and share one rectangle
    `VPWO_ASSERT_NEXT(a_byte_burst, pix_valid && !pix_stall && !pix.last_pixel, pix_valid && pix.dirty_min_x == $past(pix.dirty_min_x) && pix.dirty_max_x == $past(pix.dirty_max_x) && pix.dirty_min_y == $past(pix.dirty_min_y) && pix.dirty_max_y == $past(pix.dirty_max_y), "byte burst broken or rectangle changed mid byte")

    // the dirty rectangle is never empty in columns while a pixel item is shown
    `VPWO_ASSERT_NOW(a_rect_cols, pix_valid, pix.dirty_min_x < pix.dirty_max_x, "dirty rectangle empty in columns")

    // no items are taken as the clearing pass starts
    `VPWO_ASSERT_ALWAYS(a_reset_stall, $rose(rst_n), cmd_stall, "cmd taken during reset clearing")

endmodule

bind vram_pixel_writer_overlay_top vpwo_checker u_checker (.*);

[tb/vram_pixel_writer_overlay_top_test.sv]
// self-checking testbench for the video ram overlay pixel writer
module vram_pixel_writer_overlay_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vpwo_pkg::*;

    localparam int VRAM_BYTES = 7168;
    localparam int HALF_PERIOD = 6;
    // clearing pass plus every item at its slowest, taken many times over
    localparam int TIMEOUT_NS = 300_000 * 2 * HALF_PERIOD;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_t        cmd = '0;
    logic        pix_valid;
    logic        pix_stall = 1'b0;
    pix_t        pix;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    cmd_t        pending_cmds[$];
    pix_t        expected_pixels[$];
    logic [7:0]  vram_shadow[VRAM_BYTES];
    logic [7:0]  written_bytes[VRAM_BYTES];
    rect_t       dirty;
    cfg_t        settings;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatches = 0;

    vram_pixel_writer_overlay_top #(
        .VIDEO_BYTES (VRAM_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // works out the eight pixel items a byte write gives, and tracks the dirty rectangle
    function automatic void predict_pixels(cmd_t c);
        int unsigned off;
        coord_t      x;
        coord_t      y;
        coord_t      row;
        color_t      lit;
        pix_t        p;
        if (c.opcode == OP_CLEAR)
        begin
            dirty = RECT_EMPTY;
            return;
        end
        if (c.video_address < VIDEO_BASE || c.video_address >= VIDEO_BASE + VRAM_BYTES)
            return;
        off = c.video_address - VIDEO_BASE;
        if (vram_shadow[off] == c.data_byte)
            return;
        vram_shadow[off] = c.data_byte;
        x = coord_t'(off / 32);
        y = settings.screen_height - coord_t'(8 * (off % 32));
        if (x < dirty.left)
            dirty.left = x;
        if (coord_t'(x + 1) > dirty.right)
            dirty.right = coord_t'(x + 1);
        if (coord_t'(y - 8) < dirty.top)
            dirty.top = coord_t'(y - 8);
        if (y > dirty.bottom)
            dirty.bottom = y;
        // red band wins over both green regions
        if (y >= BAND_ORIGIN - 224 && y < BAND_ORIGIN - 192)
            lit = settings.red_color;
        else if (y >= BAND_ORIGIN - 72 && y < BAND_ORIGIN - 16)
            lit = settings.green_color;
        else if (y >= BAND_ORIGIN - 16 && x > 16 && x < 134)
            lit = settings.green_color;
        else
            lit = settings.white_color;
        for (int b = 0; b < 8; b++)
        begin
            row = y - coord_t'(b + 1);
            p.pixel_index = 20'(x) + 20'(row) * 20'(settings.screen_width);
            p.pixel_color = c.data_byte[b] ? lit : settings.black_color;
            p.last_pixel  = (b == 7);
            p.dirty_min_x = dirty.left;
            p.dirty_max_x = dirty.right;
            p.dirty_min_y = dirty.top;
            p.dirty_max_y = dirty.bottom;
            expected_pixels.push_back(p);
        end
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    function automatic void add_byte_write(logic [13:0] addr, logic [7:0] data);
        cmd_t c;
        c.opcode        = OP_WRITE;
        c.video_address = addr;
        c.data_byte     = data;
        if (addr >= VIDEO_BASE && addr < VIDEO_BASE + VRAM_BYTES)
            written_bytes[addr - VIDEO_BASE] = data;
        pending_cmds.push_back(c);
    endfunction

    function automatic void add_clear(logic [13:0] addr, logic [7:0] data);
        cmd_t c;
        c.opcode        = OP_CLEAR;
        c.video_address = addr;
        c.data_byte     = data;
        pending_cmds.push_back(c);
    endfunction

    // address of the byte in column col whose bottom edge sits 8*k below the screen height
    function automatic logic [13:0] byte_at(int col, int k);
        return 14'(VIDEO_BASE + col * 32 + k);
    endfunction

    // mostly bytes that change, with clears, rewrites and stray addresses mixed in
    function automatic void add_random_items(int changed_wanted);
        int          changed;
        int unsigned pick;
        int unsigned off;
        logic [7:0]  data;
        changed = 0;
        while (changed < changed_wanted)
        begin
            pick = $urandom_range(99);
            off  = $urandom_range(VRAM_BYTES - 1);
            if (pick < 7)
                add_clear(14'($urandom()), 8'($urandom()));
            else if (pick < 14)
                add_byte_write(14'($urandom_range(VIDEO_BASE - 1)), 8'($urandom()));
            else if (pick < 24)
                add_byte_write(14'(VIDEO_BASE + off), written_bytes[off]);
            else
            begin
                data = 8'($urandom());
                if (data == written_bytes[off])
                    data = ~data;
                add_byte_write(14'(VIDEO_BASE + off), data);
                changed++;
            end
        end
    endfunction

    task automatic write_reg(reg_index_e idx, logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SCREEN_WIDTH:  settings.screen_width  = value[COORD_W-1:0];
            REG_SCREEN_HEIGHT: settings.screen_height = value[COORD_W-1:0];
            REG_WHITE_COLOR:   settings.white_color   = value;
            REG_GREEN_COLOR:   settings.green_color   = value;
            REG_RED_COLOR:     settings.red_color     = value;
            REG_BLACK_COLOR:   settings.black_color   = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(cfg_t s);
        write_reg(REG_SCREEN_WIDTH,  32'(s.screen_width));
        write_reg(REG_SCREEN_HEIGHT, 32'(s.screen_height));
        write_reg(REG_WHITE_COLOR,   s.white_color);
        write_reg(REG_GREEN_COLOR,   s.green_color);
        write_reg(REG_RED_COLOR,     s.red_color);
        write_reg(REG_BLACK_COLOR,   s.black_color);
    endtask

    // items that give no pixels may still be in the front end, so wait on past the last expected pixel
    task automatic wait_until_drained();
        while (pending_cmds.size() > 0 || cmd_valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // command driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else if (!cmd_valid || !cmd_stall)
        begin
            if (cmd_valid)
                predict_pixels(cmd);
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd_valid <= 1'b1;
                cmd       <= pending_cmds.pop_front();
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // pixel monitor
    always @(posedge clk)
    begin : pixel_check
        pix_t want;
        if (!rst_n)
        begin
            pix_stall <= 1'b0;
        end
        else
        begin
            if (pix_valid && !pix_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel item with nothing expected: index 0x%0h", pix.pixel_index);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    compare_field("pixel_index", 32'(want.pixel_index), 32'(pix.pixel_index));
                    compare_field("pixel_color", want.pixel_color, pix.pixel_color);
                    compare_field("last_pixel", 32'(want.last_pixel), 32'(pix.last_pixel));
                    compare_field("dirty_min_x", 32'(want.dirty_min_x), 32'(pix.dirty_min_x));
                    compare_field("dirty_max_x", 32'(want.dirty_max_x), 32'(pix.dirty_max_x));
                    compare_field("dirty_min_y", 32'(want.dirty_min_y), 32'(pix.dirty_min_y));
                    compare_field("dirty_max_y", 32'(want.dirty_max_y), 32'(pix.dirty_max_y));
                end
            end
            pix_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        for (int i = 0; i < VRAM_BYTES; i++)
        begin
            vram_shadow[i]   = '0;
            written_bytes[i] = '0;
        end
        dirty    = RECT_EMPTY;
        settings = '{11'd224, 11'd256, 32'hFFFF_FFFF, 32'hFF00_FF00, 32'hFF00_00FF,
                     32'hFF00_0000};
        send_idle_pct = 34;
        recv_idle_pct = 61;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // registers are taken during the clearing pass
        apply_settings('{11'd224, 11'd256, 32'hFFFF_FFFF, 32'hFF00_FF00, 32'hFF00_00FF,
                         32'h0000_0000});

        // first byte, last byte, unchanged, stray addresses, clear
        add_byte_write(byte_at(0, 0), 8'hFF);
        add_byte_write(14'h3FFF, 8'h01);
        add_byte_write(14'h3FFF, 8'h01);
        add_byte_write(14'(VIDEO_BASE - 1), 8'hAA);
        add_byte_write(14'h0000, 8'hFF);
        add_clear(14'h3FFF, 8'hFF);
        add_byte_write(byte_at(0, 0), 8'h00);
        // red band and its edges
        add_byte_write(byte_at(5, 24), 8'hA5);
        add_byte_write(byte_at(6, 23), 8'h3C);
        add_byte_write(byte_at(7, 27), 8'h81);
        add_byte_write(byte_at(7, 28), 8'h7E);
        // green band and the partial bottom strip
        add_byte_write(byte_at(50, 8), 8'h0F);
        add_byte_write(byte_at(60, 2), 8'hF0);
        add_byte_write(byte_at(10, 1), 8'h55);
        add_byte_write(byte_at(16, 0), 8'hC3);
        add_byte_write(byte_at(17, 0), 8'h99);
        add_byte_write(byte_at(133, 1), 8'h66);
        add_byte_write(byte_at(134, 1), 8'hE7);
        add_byte_write(byte_at(100, 16), 8'h18);
        add_clear(14'h0000, 8'h00);
        add_byte_write(byte_at(223, 31), 8'hFE);
        add_byte_write(byte_at(120, 12), 8'h42);
        add_random_items(26);
        wait_until_drained();

        send_idle_pct = 61;
        recv_idle_pct = 34;
        apply_settings('{11'd1024, 11'd1024, 32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF,
                         32'h8000_0001});
        add_byte_write(byte_at(0, 0), 8'h5A);
        add_byte_write(byte_at(223, 31), 8'h01);
        add_random_items(26);
        wait_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings('{11'($urandom_range(1024, 224)), 11'($urandom_range(1024, 256)),
                         32'($urandom()), 32'($urandom()), 32'($urandom()), 32'($urandom())});
        add_random_items(26);
        wait_until_drained();

        if (mismatches == 0)
            $display("** vram_pixel_writer_overlay_top: PASSED **");
        else
            $display("** vram_pixel_writer_overlay_top: FAILED **");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("** vram_pixel_writer_overlay_top: FAILED **");
        $finish;
    end

endmodule
